FILE: rtl/lpe_pkg.sv
`timescale 1ns / 1ps

package lpe_pkg;

    // array geometry
    localparam int NUM_SENSORS    = 6;
    localparam int SENSOR_SPACING = 1000;
    localparam int FIELD_COUNT    = 6;

    // widths of the datapath
    localparam int RD_W     = 10;
    localparam int POS_W    = 13;
    localparam int POS_MAX  = 8191;
    localparam int READ_MAX = 1023;
    localparam int SPAN     = (NUM_SENSORS - 1) * SENSOR_SPACING;
    localparam int CENTER   = SPAN / 2;
    localparam int QUOT_W   = $clog2(SPAN + 1);
    localparam int PLAIN_W  = $clog2(NUM_SENSORS * READ_MAX + 1);
    localparam int WSUM_W   =
        $clog2(READ_MAX * SENSOR_SPACING * (NUM_SENSORS * (NUM_SENSORS - 1) / 2) + 1);
    localparam int STEP_W   = $clog2(NUM_SENSORS);
    localparam int CMP_W    = (QUOT_W > POS_W) ? QUOT_W : POS_W;
    localparam int RIGHT_POS = (SPAN > POS_MAX) ? POS_MAX : SPAN;

    // configuration port
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD  = CFG_IDX_W'(1);

    localparam logic [RD_W-1:0] NOISE_RESET = RD_W'(200);
    localparam logic [RD_W-1:0] LINE_RESET  = RD_W'(500);

    typedef struct packed {
        logic [RD_W-1:0] sensor_0;
        logic [RD_W-1:0] sensor_1;
        logic [RD_W-1:0] sensor_2;
        logic [RD_W-1:0] sensor_3;
        logic [RD_W-1:0] sensor_4;
        logic [RD_W-1:0] sensor_5;
    } sample_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_seen;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/line_position_estimator.sv
`timescale 1ns / 1ps

// Line position estimator for a reflectance sensor array. Each request carries one 10-bit
// reading per sensor; readings above noise_threshold build a plain sum and a sum weighted by
// sensor index times the sensor spacing, and their truncated quotient is the line position
// (0 under sensor 0, 1000 per sensor step). If no reading exceeds line_threshold, or the
// plain sum is zero, the result is a fallback of 0 or the rightmost position, chosen by the
// last computed position, with line_seen low. A request makes a multiply-accumulate pass,
// one sensor per cycle on a single multiplier, then runs a restoring divider with one
// quotient bit per cycle (13 bits), plus sequencing states; a line-lost request skips the
// divider. sample_ready is high only while idle. A finished result waits in an output
// register, so the next request is taken while it is pending. Configuration is written
// through cfg_index / cfg_data; cfg_ready is always high and writes to unknown indices
// are dropped.

module line_position_estimator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  lpe_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output lpe_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpe_pkg::RD_W-1:0]          cfg_data
);

    lpe_pkg::state_t                  state_reg;
    lpe_pkg::state_t                  state_next;

    logic [lpe_pkg::RD_W-1:0]         noise_reg;
    logic [lpe_pkg::RD_W-1:0]         line_reg;
    logic [lpe_pkg::POS_W-1:0]        last_pos_reg;

    logic [lpe_pkg::RD_W-1:0]         sample_reg [lpe_pkg::FIELD_COUNT];
    logic [lpe_pkg::STEP_W-1:0]       step_reg;
    logic [lpe_pkg::QUOT_W-1:0]       weight_reg;
    logic [lpe_pkg::WSUM_W-1:0]       wsum_reg;
    logic [lpe_pkg::WSUM_W-1:0]       wsum_next;
    logic [lpe_pkg::PLAIN_W-1:0]      plain_reg;
    logic [lpe_pkg::PLAIN_W-1:0]      plain_next;
    logic                             seen_reg;
    logic                             fallback_reg;

    lpe_pkg::result_t                 result_reg;
    lpe_pkg::result_t                 result_next;
    logic                             result_valid_reg;

    logic                             accept;
    logic                             accum_en;
    logic                             check_en;
    logic                             div_start;
    logic                             finish_load;
    logic                             last_step;
    logic                             fallback;
    logic [lpe_pkg::RD_W-1:0]         reading;
    logic                             counts;
    logic [lpe_pkg::RD_W+lpe_pkg::QUOT_W-1:0] product;

    logic                             div_done;
    logic [lpe_pkg::QUOT_W-1:0]       quotient;
    logic [lpe_pkg::CMP_W-1:0]        quot_ext;
    logic [lpe_pkg::POS_W-1:0]        quot_pos;
    logic [lpe_pkg::POS_W-1:0]        fallback_pos;

    assign cfg_ready = 1'b1;
    assign accept    = sample_valid && sample_ready;
    assign last_step = (step_reg == lpe_pkg::STEP_W'(lpe_pkg::NUM_SENSORS - 1));
    assign fallback  = !seen_reg || (plain_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpe_pkg::ST_IDLE:
                if (sample_valid)
                    state_next = lpe_pkg::ST_ACCUM;
            lpe_pkg::ST_ACCUM:
                if (last_step)
                    state_next = lpe_pkg::ST_CHECK;
            lpe_pkg::ST_CHECK:
                state_next = fallback ? lpe_pkg::ST_FINISH : lpe_pkg::ST_DIVIDE;
            lpe_pkg::ST_DIVIDE:
                if (div_done)
                    state_next = lpe_pkg::ST_FINISH;
            lpe_pkg::ST_FINISH:
                if (!result_valid_reg || result_ready)
                    state_next = lpe_pkg::ST_IDLE;
            default:
                state_next = lpe_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_ready = 1'b0;
        accum_en     = 1'b0;
        check_en     = 1'b0;
        div_start    = 1'b0;
        finish_load  = 1'b0;
        unique case (state_reg)
            lpe_pkg::ST_IDLE:   sample_ready = 1'b1;
            lpe_pkg::ST_ACCUM:  accum_en     = 1'b1;
            lpe_pkg::ST_CHECK:
            begin
                check_en  = 1'b1;
                div_start = !fallback;
            end
            lpe_pkg::ST_DIVIDE: ;
            lpe_pkg::ST_FINISH: finish_load = !result_valid_reg || result_ready;
            default: ;
        endcase
    end

    // shared multiply-accumulate, one sensor per cycle from the bottom of the shift line
    always_comb
    begin
        reading    = sample_reg[0];
        counts     = (reading > noise_reg);
        product    = reading * weight_reg;
        wsum_next  = counts ? wsum_reg + lpe_pkg::WSUM_W'(product) : wsum_reg;
        plain_next = counts ? plain_reg + lpe_pkg::PLAIN_W'(reading) : plain_reg;
    end

    // result formatting
    always_comb
    begin
        quot_ext = lpe_pkg::CMP_W'(quotient);
        if (quot_ext > lpe_pkg::CMP_W'(lpe_pkg::POS_MAX))
            quot_pos = lpe_pkg::POS_W'(lpe_pkg::POS_MAX);
        else
            quot_pos = quot_ext[lpe_pkg::POS_W-1:0];

        if (lpe_pkg::CMP_W'(last_pos_reg) < lpe_pkg::CMP_W'(lpe_pkg::CENTER))
            fallback_pos = '0;
        else
            fallback_pos = lpe_pkg::POS_W'(lpe_pkg::RIGHT_POS);

        if (fallback_reg)
        begin
            result_next.position  = fallback_pos;
            result_next.line_seen = 1'b0;
        end
        else
        begin
            result_next.position  = quot_pos;
            result_next.line_seen = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lpe_pkg::ST_IDLE;
            noise_reg        <= lpe_pkg::NOISE_RESET;
            line_reg         <= lpe_pkg::LINE_RESET;
            last_pos_reg     <= '0;
            result_valid_reg <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lpe_pkg::CFG_NOISE_THRESHOLD: noise_reg <= cfg_data;
                    lpe_pkg::CFG_LINE_THRESHOLD:  line_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
                step_reg <= '0;
            else if (accum_en)
                step_reg <= step_reg + lpe_pkg::STEP_W'(1);

            if (finish_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (finish_load && !fallback_reg)
                last_pos_reg <= quot_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg[0] <= sample.sensor_0;
            sample_reg[1] <= sample.sensor_1;
            sample_reg[2] <= sample.sensor_2;
            sample_reg[3] <= sample.sensor_3;
            sample_reg[4] <= sample.sensor_4;
            sample_reg[5] <= sample.sensor_5;
            weight_reg    <= '0;
            wsum_reg      <= '0;
            plain_reg     <= '0;
            seen_reg      <= 1'b0;
        end
        else if (accum_en)
        begin
            // sensors past the last field shift in as zero
            for (int i = 0; i < lpe_pkg::FIELD_COUNT - 1; i++)
                sample_reg[i] <= sample_reg[i+1];
            sample_reg[lpe_pkg::FIELD_COUNT-1] <= '0;
            weight_reg <= weight_reg + lpe_pkg::QUOT_W'(lpe_pkg::SENSOR_SPACING);
            wsum_reg   <= wsum_next;
            plain_reg  <= plain_next;
            if (reading > line_reg)
                seen_reg <= 1'b1;
        end

        if (check_en)
            fallback_reg <= fallback;

        if (finish_load)
            result_reg <= result_next;
    end

    lpe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wsum_reg),
        .divisor  (plain_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/lpe_divider.sv
`timescale 1ns / 1ps

module lpe_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lpe_pkg::WSUM_W-1:0]       dividend,
    input  logic [lpe_pkg::PLAIN_W-1:0]      divisor,
    output logic                             done,
    output logic [lpe_pkg::QUOT_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(lpe_pkg::QUOT_W + 1);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [lpe_pkg::PLAIN_W-1:0]    rem_reg;
    logic [lpe_pkg::PLAIN_W-1:0]    rem_next;
    logic [lpe_pkg::QUOT_W-1:0]     quot_reg;
    logic [lpe_pkg::QUOT_W-1:0]     quot_next;
    logic [lpe_pkg::PLAIN_W:0]      shifted;
    logic [lpe_pkg::PLAIN_W:0]      diff;
    logic                           fits;

    // one restoring step: quotient bit enters at the bottom as dividend bits leave the top
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[lpe_pkg::QUOT_W-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = (shifted >= {1'b0, divisor});
        rem_next  = fits ? diff[lpe_pkg::PLAIN_W-1:0] : shifted[lpe_pkg::PLAIN_W-1:0];
        quot_next = {quot_reg[lpe_pkg::QUOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(lpe_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // high part of the dividend is already below the divisor, since the quotient fits QUOT_W
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= lpe_pkg::PLAIN_W'(dividend >> lpe_pkg::QUOT_W);
            quot_reg <= dividend[lpe_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: verif/lpe_checker.sv
`timescale 1ns / 1ps

module lpe_checker
    import lpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_ready,
    input  sample_t              sample,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RD_W-1:0]      cfg_data,
    output int                   mismatch_count,
    output int                   pending_results,
    output int                   results_seen
);

    logic [RD_W-1:0]  noise_level;
    logic [RD_W-1:0]  line_level;
    logic [POS_W-1:0] kept_position;
    result_t          position_queue [$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [POS_W-1:0] clamp_position(input longint unsigned v);
        return (v > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(v);
    endfunction

    function automatic result_t estimate_position(input sample_t s);
        logic [RD_W-1:0]   field_reading [FIELD_COUNT];
        logic [RD_W-1:0]   reading;
        longint unsigned   weighted;
        longint unsigned   plain;
        bit                seen;
        result_t           r;

        field_reading = '{s.sensor_0, s.sensor_1, s.sensor_2,
                          s.sensor_3, s.sensor_4, s.sensor_5};
        weighted = 0;
        plain    = 0;
        seen     = 1'b0;
        for (int k = 0; k < NUM_SENSORS; k++)
        begin
            // sensors without an input field read as zero
            reading = (k < FIELD_COUNT) ? field_reading[k] : '0;
            if (reading > line_level)
                seen = 1'b1;
            if (reading > noise_level)
            begin
                weighted += longint'(reading) * longint'(k) * longint'(SENSOR_SPACING);
                plain    += reading;
            end
        end
        if (!seen || plain == 0)
        begin
            // line lost: fall back to the side where it was last seen
            r.position  = (kept_position < CENTER) ? '0 : clamp_position(SPAN);
            r.line_seen = 1'b0;
        end
        else
        begin
            kept_position = clamp_position(weighted / plain);
            r.position    = kept_position;
            r.line_seen   = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;

        if (!rst_n)
        begin
            noise_level   = NOISE_RESET;
            line_level    = LINE_RESET;
            kept_position = '0;
            position_queue.delete();
            pending_results <= 0;
            results_seen    <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (position_queue.size() == 0)
                    report_mismatch("result with no pending request", result.position, 0);
                else
                begin
                    want = position_queue.pop_front();
                    if (result.position !== want.position)
                        report_mismatch("position", result.position, want.position);
                    if (result.line_seen !== want.line_seen)
                        report_mismatch("line_seen", result.line_seen, want.line_seen);
                end
                results_seen <= results_seen + 1;
            end
            if (sample_valid && sample_ready)
                position_queue.push_back(estimate_position(sample));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NOISE_THRESHOLD)
                    noise_level = cfg_data;
                else if (cfg_index == CFG_LINE_THRESHOLD)
                    line_level = cfg_data;
            end
            pending_results <= position_queue.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lpe_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int RANDOM_PER_PHASE = 305;
    localparam int HOLD_AFTER      = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(8'hA5);

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_t              sample       = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [RD_W-1:0]      cfg_data     = '0;

    int mismatch_count;
    int pending_results;
    int results_seen;

    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 46;
    int unsigned cur_noise     = 200;
    int unsigned cur_line      = 500;

    always #5 clk = ~clk;

    line_position_estimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lpe_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    function automatic sample_t frame(input int r0, input int r1, input int r2,
                                      input int r3, input int r4, input int r5);
        sample_t s;

        s.sensor_0 = RD_W'(r0);
        s.sensor_1 = RD_W'(r1);
        s.sensor_2 = RD_W'(r2);
        s.sensor_3 = RD_W'(r3);
        s.sensor_4 = RD_W'(r4);
        s.sensor_5 = RD_W'(r5);
        return s;
    endfunction

    function automatic int clip_reading(input int v);
        return (v < 0) ? 0 : ((v > READ_MAX) ? READ_MAX : v);
    endfunction

    // most often a line under one or two sensors, the rest noise, lost lines and edge values
    function automatic sample_t random_frame();
        int rd [6];
        int kind;
        int peak;
        int wide;
        int pick;

        kind = $urandom_range(0, 99);
        peak = $urandom_range(0, 5);
        wide = $urandom_range(0, 1);
        for (int k = 0; k < 6; k++)
        begin
            if (kind < 30)
                rd[k] = $urandom_range(0, READ_MAX);
            else if (kind < 70)
            begin
                if (k == peak || (wide && k == peak + 1))
                    rd[k] = $urandom_range(600, READ_MAX);
                else
                    rd[k] = $urandom_range(0, 300);
            end
            else if (kind < 85)
                rd[k] = $urandom_range(0, 450);
            else
            begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0, 1, 2: rd[k] = clip_reading(int'(cur_noise) + pick - 1);
                    3, 4, 5: rd[k] = clip_reading(int'(cur_line) + pick - 4);
                    6:       rd[k] = 0;
                    default: rd[k] = READ_MAX;
                endcase
            end
        end
        return frame(rd[0], rd[1], rd[2], rd[3], rd[4], rd[5]);
    endfunction

    task automatic send_sample(input sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // valid stays up across back-to-back writes, the caller drops it after the last one
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= RD_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_NOISE_THRESHOLD)
            cur_noise = value;
        else if (idx == CFG_LINE_THRESHOLD)
            cur_line = value;
    endtask

    // result side, with one long hold-off so the block backs up into its input
    initial
    begin
        bit held_off;

        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned noise_setting [NUM_PHASES];
        int unsigned line_setting  [NUM_PHASES];

        noise_setting = '{200, 0, 1023, 1023, 0, 150};
        line_setting  = '{500, 0, 1023, 0, 0, 600};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            send_idle_pct = (phase < 2) ? 30 : ((phase < 4) ? 46 : 0);
            recv_idle_pct = (phase < 2) ? 46 : ((phase < 4) ? 30 : 0);
            if (phase == 4)
            begin
                noise_setting[phase] = $urandom_range(0, READ_MAX);
                line_setting[phase]  = $urandom_range(0, READ_MAX);
            end
            // first phase runs on the reset values
            if (phase > 0)
            begin
                write_register(CFG_NOISE_THRESHOLD, noise_setting[phase]);
                write_register(CFG_LINE_THRESHOLD, line_setting[phase]);
            end
            if (phase == 5)
                write_register(CFG_UNUSED_INDEX, 10'h3FF);
            if (phase > 0)
                cfg_valid <= 1'b0;

            case (phase)
                0:
                begin
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    send_sample(frame(1023, 1023, 1023, 1023, 1023, 1023));
                    // stored position sits exactly on center: fallback goes right
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    send_sample(frame(1023, 0, 0, 0, 0, 0));
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    send_sample(frame(0, 1023, 0, 0, 0, 0));
                    send_sample(frame(0, 0, 1023, 0, 0, 0));
                    send_sample(frame(0, 0, 0, 1023, 0, 0));
                    send_sample(frame(0, 0, 0, 0, 1023, 0));
                    send_sample(frame(0, 0, 0, 0, 0, 1023));
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    // readings equal to the thresholds do not count
                    send_sample(frame(500, 500, 200, 500, 200, 500));
                    send_sample(frame(200, 200, 501, 200, 200, 200));
                    send_sample(frame(0, 0, 201, 501, 0, 0));
                    // just left of center, then lost
                    send_sample(frame(0, 0, 1002, 1000, 0, 0));
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    send_sample(frame(10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA, 10'h2AA));
                    send_sample(frame(10'h155, 10'h155, 10'h155, 10'h155, 10'h155, 10'h155));
                    send_sample(frame(1023, 0, 0, 0, 0, 1023));
                end
                1:
                begin
                    send_sample(frame(0, 0, 0, 0, 0, 0));
                    send_sample(frame(0, 0, 0, 0, 0, 1));
                end
                3:
                begin
                    // line seen but nothing above the noise level
                    send_sample(frame(1, 1, 1, 1, 1, 1));
                    send_sample(frame(1023, 1023, 1023, 1023, 1023, 1023));
                end
                default: ;
            endcase

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_sample(random_frame());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
